// ===== src/assert_macros.svh =====
// Assertion macros used by the track follower back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held.
`define TCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcf assertion failed");

`else

`define TCF_ASSERT_IMP(lbl, ante, cons)
`define TCF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== src/tcf_pkg.sv =====
// Shared types and constants of the track follower.
package tcf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 9;
  localparam int COL_W  = 10;
  localparam int CEN_W  = 11;
  localparam int TW_W   = 12;
  localparam int DEL_W  = 11;
  localparam int WC_W   = 11;
  localparam int CFG_W  = 11;
  localparam int CFG_AW = 2;
  localparam int FW_W   = 11;
  localparam int FH_W   = 10;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER_COLUMN = 2'd2;

  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH   = 11'd640;
  localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT  = 10'd330;
  localparam logic [COL_W-1:0] RST_CENTER_COLUMN = 10'd320;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_WHITE = 2'd1,
    CLS_BLACK = 2'd2
  } cls_t;

  typedef struct packed {
    logic frame_start;
    cls_t cls;
  } tcf_word_t;

  typedef struct packed {
    logic              frame_done;
    logic              track_lost;
    logic [DEL_W-1:0]  column_delta;
    logic [TW_W-1:0]   track_width;
    logic [CEN_W-1:0]  centered_column;
    logic [COL_W-1:0]  track_column;
    logic [ROW_W-1:0]  row_index;
  } tcf_result_t;

endpackage

// ===== src/tcf_front.sv =====
// Front end: classify incoming pixels and queue them for the back end.
module tcf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [tcf_pkg::PIX_W-1:0] in_pixel,
  input  logic                      in_frame_start,
  output logic                      q_valid,
  output tcf_pkg::tcf_word_t        q_word,
  input  logic                      q_pop
);
  import tcf_pkg::*;

  tcf_word_t        fifo_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push;
  tcf_word_t        push_word;

  always_comb begin
    push_word.frame_start = in_frame_start;
    if (in_pixel == PIX_WHITE) begin
      push_word.cls = CLS_WHITE;
    end else if (in_pixel == PIX_BLACK) begin
      push_word.cls = CLS_BLACK;
    end else begin
      push_word.cls = CLS_NONE;
    end
  end

  assign in_tready = (cnt_r != QCW'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_word    = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== src/tcf_back.sv =====
// Back end: row store, row bookkeeping, edge search and result register.
`include "assert_macros.svh"

module tcf_back #(
  parameter int MAX_WIDTH  = tcf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tcf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     eff_height,
  input  logic [tcf_pkg::COL_W-1:0]           center_column,
  input  logic                                q_valid,
  input  tcf_pkg::tcf_word_t                  q_word,
  output logic                                q_pop,
  output logic                                res_valid,
  input  logic                                res_ready,
  output tcf_pkg::tcf_result_t                res_word
);
  import tcf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = WW + 1;

  typedef enum logic [4:0] {
    ST_STREAM = 5'b00001,
    ST_SEED   = 5'b00010,
    ST_LEFT   = 5'b00100,
    ST_RIGHT  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [WC_W-1:0]   wc_r, wc_nxt;
  logic [COL_W-1:0]  prev_r, prev_nxt;
  logic              stopped_r, stopped_nxt;
  logic [CW-1:0]     seed_r, seed_nxt;
  logic [WW-1:0]     left_r, left_nxt;
  logic [SW-1:0]     right_r, right_nxt;
  logic              lost_r, lost_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic [WW-1:0]     n_r, n_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]     chk_idx_r, chk_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcf_result_t       out_word_r, out_word_nxt;

  cls_t              mem [MAX_WIDTH];
  cls_t              rd_data_r;
  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  logic              rd_en;
  logic [CW-1:0]     rd_addr;

  logic              s_fs, s_stop, s_last;
  logic [CW-1:0]     s_col, seed_clamp;
  logic [ROW_W-1:0]  s_row;
  logic [WC_W-1:0]   s_wc, s_wc_new;
  logic              issue_up, issue_dn;
  logic [WW-1:0]     n_new;
  logic              n_hit;
  logic [SW-1:0]     edge_sum;
  logic [COL_W-1:0]  r_track;
  logic              r_done;
  tcf_result_t       r_word;

  // Stream-side view with a frame start applied.
  always_comb begin
    s_fs     = q_word.frame_start;
    s_col    = s_fs ? '0 : col_r;
    s_row    = s_fs ? '0 : row_r;
    s_wc     = s_fs ? '0 : wc_r;
    s_stop   = s_fs ? 1'b0 : stopped_r;
    s_wc_new = (s_row == '0 && q_word.cls == CLS_WHITE) ? s_wc + WC_W'(1) : s_wc;
    s_last   = (WW'(s_col) + WW'(1)) >= eff_width;
    if (32'(prev_r) > 32'(eff_width) - 32'd1) begin
      seed_clamp = CW'(eff_width - WW'(1));
    end else begin
      seed_clamp = CW'(prev_r);
    end
  end

  always_comb begin
    issue_up = scan_r < SW'(eff_width);
    issue_dn = !scan_r[SW-1];
    n_new    = n_r + WW'(rd_data_r == CLS_WHITE);
    n_hit    = 32'(n_new) == 32'(wc_r >> 1);
    edge_sum = SW'(left_r) + right_r;
  end

  // Result of the finished search.
  always_comb begin
    if (lost_r) begin
      r_track = '0;
    end else if (row_r == '0) begin
      r_track = COL_W'(seed_r);
    end else begin
      r_track = COL_W'(edge_sum >> 1);
    end
    r_done = lost_r || ((32'(row_r) + 32'd1) >= 32'(eff_height));
    r_word.row_index    = row_r;
    r_word.track_column = r_track;
    r_word.track_lost   = lost_r;
    r_word.frame_done   = r_done;
    if (lost_r) begin
      r_word.centered_column = '0;
      r_word.track_width     = '0;
      r_word.column_delta    = '0;
    end else begin
      r_word.centered_column = CEN_W'(r_track) - CEN_W'(center_column);
      r_word.track_width     = TW_W'($signed(right_r)) - TW_W'(left_r);
      r_word.column_delta    = (row_r == '0) ? '0 : DEL_W'(r_track) - DEL_W'(prev_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    wc_nxt        = wc_r;
    prev_nxt      = prev_r;
    stopped_nxt   = stopped_r;
    seed_nxt      = seed_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    lost_nxt      = lost_r;
    scan_nxt      = scan_r;
    n_nxt         = n_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = s_col;
    rd_en         = 1'b0;
    rd_addr       = scan_r[CW-1:0];
    out_valid_nxt = out_valid_r && !res_ready;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_STREAM: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (s_fs) begin
            col_nxt     = '0;
            row_nxt     = '0;
            wc_nxt      = '0;
            stopped_nxt = 1'b0;
          end
          if (!s_stop) begin
            mem_we = 1'b1;
            wc_nxt = s_wc_new;
            if (!s_last) begin
              col_nxt = s_col + CW'(1);
            end else begin
              col_nxt  = '0;
              lost_nxt = 1'b0;
              n_nxt    = '0;
              if (s_row == '0) begin
                seed_nxt  = '0;
                scan_nxt  = '0;
                state_nxt = (s_wc_new >= WC_W'(2)) ? ST_SEED : ST_LEFT;
              end else begin
                seed_nxt  = seed_clamp;
                scan_nxt  = SW'(seed_clamp);
                state_nxt = ST_LEFT;
              end
            end
          end
        end
      end
      ST_SEED: begin
        if (issue_up) begin
          rd_en       = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[CW-1:0];
          scan_nxt    = scan_r + SW'(1);
        end
        if (chk_vld_r) begin
          n_nxt = n_new;
          if (n_hit) begin
            seed_nxt    = chk_idx_r;
            scan_nxt    = SW'(chk_idx_r);
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_LEFT;
          end
        end else if (!issue_up) begin
          seed_nxt  = '0;
          scan_nxt  = '0;
          state_nxt = ST_LEFT;
        end
      end
      ST_LEFT: begin
        if (issue_dn) begin
          rd_en       = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[CW-1:0];
          scan_nxt    = scan_r - SW'(1);
        end
        if (chk_vld_r) begin
          if (row_r != '0 && chk_idx_r == seed_r && rd_data_r != CLS_WHITE) begin
            lost_nxt    = 1'b1;
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else if (rd_data_r == CLS_BLACK) begin
            left_nxt    = WW'(chk_idx_r) + WW'(1);
            scan_nxt    = SW'(seed_r);
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_RIGHT;
          end
        end else if (!issue_dn) begin
          left_nxt  = '0;
          scan_nxt  = SW'(seed_r);
          state_nxt = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        if (issue_up) begin
          rd_en       = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[CW-1:0];
          scan_nxt    = scan_r + SW'(1);
        end
        if (chk_vld_r) begin
          if (rd_data_r == CLS_BLACK) begin
            right_nxt   = SW'(chk_idx_r) - SW'(1);
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end
        end else if (!issue_up) begin
          right_nxt = SW'(eff_width);
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = r_word;
          if (!lost_r) begin
            prev_nxt = r_track;
          end
          if (r_done) begin
            stopped_nxt = 1'b1;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
          state_nxt = ST_STREAM;
        end
      end
      default: begin
        state_nxt = ST_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_STREAM;
      col_r       <= '0;
      row_r       <= '0;
      wc_r        <= '0;
      prev_r      <= '0;
      stopped_r   <= 1'b1;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      wc_r        <= wc_nxt;
      prev_r      <= prev_nxt;
      stopped_r   <= stopped_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r     <= seed_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    lost_r     <= lost_nxt;
    scan_r     <= scan_nxt;
    n_r        <= n_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_word_r <= out_word_nxt;
  end

  // Row store: one write port for the stream, one registered read port for the search.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= q_word.cls;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign res_valid = out_valid_r;
  assign res_word  = out_word_r;

  `TCF_ASSERT_IMP(a_chk_only_in_scan, chk_vld_r,
    (state_r == ST_SEED || state_r == ST_LEFT || state_r == ST_RIGHT))
  `TCF_ASSERT_IMP(a_left_scan_below_seed, chk_vld_r && state_r == ST_LEFT,
    chk_idx_r <= seed_r)
  `TCF_ASSERT_IMP(a_run_covers_seed, state_r == ST_RESULT && !lost_r && row_r != '0,
    (left_r <= WW'(seed_r)) && !right_r[SW-1] && (right_r >= SW'(seed_r)))
  `TCF_ASSERT_NXT(a_done_stops_frame, state_r == ST_RESULT && state_nxt == ST_STREAM && r_done,
    stopped_r)

endmodule

// ===== src/track_center_line_follower_core.sv =====
// Track follower top: one pixel word per cycle while a row streams in and the queue has room.
// After the last pixel of a row the row store is searched with one read per cycle: the seed
// scan (first row only), then the left and right scans, and the result register loads once
// the output is free; meanwhile only the 4-word queue takes input.
// Reset (synchronous, rst_n low) clears control state and loads the register defaults;
// the block then drops pixels until a word with tuser set; the row store is not cleared.
module track_center_line_follower_core #(
  parameter int MAX_WIDTH  = tcf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tcf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] pixel
  input  logic                       in_tuser,   // [0] frame_start
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [8:0] row_index, [18:9] track_column, [29:19] centered_column,
  // [41:30] track_width, [52:42] column_delta, [55:53] zero
  output logic [55:0]                out_tdata,
  output logic                       out_tuser,  // [0] track_lost
  output logic                       out_tlast,  // frame_done
  input  logic                       cfg_we,
  input  logic [tcf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tcf_pkg::CFG_W-1:0]  cfg_wdata
);
  import tcf_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Configuration registers, to be written only while the block is idle; the block does not enforce it.
  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic [COL_W-1:0]  center_column_r;

  // Saturated frame geometry seen by the back end.
  logic [WW-1:0]     eff_width;
  logic [HW-1:0]     eff_height;

  logic              q_valid;
  logic              q_pop;
  tcf_word_t         q_word;
  tcf_result_t       res_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      center_column_r <= RST_CENTER_COLUMN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_wdata[FW_W-1:0];
        end
        REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wdata[FH_W-1:0];
        end
        REG_CENTER_COLUMN: begin
          center_column_r <= cfg_wdata[COL_W-1:0];
        end
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Clamp width to 1..MAX_WIDTH and height to 1..MAX_HEIGHT.
  always_comb begin
    if (frame_width_r == '0) begin
      eff_width = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_height = HW'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      eff_height = HW'(MAX_HEIGHT);
    end else begin
      eff_height = HW'(frame_height_r);
    end
  end

  // Front: classify each pixel word as white, black or neither and queue it.
  tcf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_pixel       (in_tdata[PIX_W-1:0]),
    .in_frame_start (in_tuser),
    .q_valid        (q_valid),
    .q_word         (q_word),
    .q_pop          (q_pop)
  );

  // Back: keep the row, search it at the row end and hold the result word.
  tcf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .eff_width     (eff_width),
    .eff_height    (eff_height),
    .center_column (center_column_r),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .q_pop         (q_pop),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_word      (res_word)
  );

  // Pack the result word, first field in the low bits.
  assign out_tdata = {3'b000,
                      res_word.column_delta,
                      res_word.track_width,
                      res_word.centered_column,
                      res_word.track_column,
                      res_word.row_index};
  assign out_tuser = res_word.track_lost;
  assign out_tlast = res_word.frame_done;

endmodule

// ===== sim/track_center_line_follower_core_tb.sv =====
// Self-checking testbench for the track follower core: pixel stimulus and row result checks.
module track_center_line_follower_core_tb;
  import tcf_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;

  // One row result as it leaves the block.
  typedef struct packed {
    logic [8:0]  row;
    logic [9:0]  col;
    logic [10:0] cen;
    logic [11:0] wid;
    logic [10:0] dlt;
    logic        lost;
    logic        done;
  } row_result_t;

  // How the content of a generated row is laid out.
  typedef enum logic [1:0] {
    ROW_TRACK,  // white run around the seed column, black borders
    ROW_HOLE,   // same, but the seed pixel is not white
    ROW_NOISE,  // anything goes
    ROW_WHITE   // every pixel white
  } row_shape_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [55:0]         out_tdata;
  logic                out_tuser;
  logic                out_tlast;
  logic                cfg_we     = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr   = '0;
  logic [CFG_W-1:0]    cfg_wdata  = '0;

  track_center_line_follower_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Mirror of the configuration registers, loaded with their reset values.
  logic [10:0] reg_width  = RST_FRAME_WIDTH;
  logic [9:0]  reg_height = RST_FRAME_HEIGHT;
  logic [9:0]  reg_center = RST_CENTER_COLUMN;

  // Tracker state: row buffer of pixel classes, counters and the last track column.
  cls_t        row_cls [MAX_W];
  logic [10:0] trk_whites  = '0;
  int          trk_col_cnt = 0;
  int          trk_row     = 0;
  int          trk_prev    = 0;
  bit          trk_stopped = 1'b1;

  row_result_t expected_rows[$];
  int          rows_predicted = 0;
  int          pixels_sent    = 0;
  int          mismatches     = 0;
  int          out_hold       = 0;
  bit          tx_calm        = 1'b0;
  bit          rx_calm        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #2_000_000;
    $display("** track_center_line_follower_core: FAILED **");
    $finish;
  end

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_W) return MAX_W;
    return int'(reg_width);
  endfunction

  function automatic int eff_height();
    if (reg_height == 0) return 1;
    if (reg_height > MAX_H) return MAX_H;
    return int'(reg_height);
  endfunction

  // Search the buffered row outward from the seed for the nearest black pixels.
  function automatic void find_edges(input int seed, input int w, output int lft,
                                     output int rgt);
    lft = 0;
    for (int i = seed; i >= 0; i--) begin
      if (row_cls[i] == CLS_BLACK) begin
        lft = i + 1;
        break;
      end
    end
    rgt = w;
    for (int i = seed; i < w; i++) begin
      if (row_cls[i] == CLS_BLACK) begin
        rgt = i - 1;
        break;
      end
    end
  endfunction

  // Advance the tracker by one accepted pixel word; queue a row result at the end of a row.
  task automatic track_pixel(input logic [7:0] pix, input logic fs);
    int          w, h, col, seed, trk, n, lft, rgt, wid, dlt, cen;
    bit          lost, done;
    cls_t        cls;
    row_result_t res;
    w    = eff_width();
    h    = eff_height();
    trk  = 0;
    wid  = 0;
    dlt  = 0;
    cen  = 0;
    lost = 1'b0;
    if (fs) begin
      trk_col_cnt = 0;
      trk_row     = 0;
      trk_whites  = '0;
      trk_stopped = 1'b0;
    end
    if (trk_stopped) return;

    col = (trk_col_cnt >= MAX_W) ? MAX_W - 1 : trk_col_cnt;
    cls = (pix == PIX_WHITE) ? CLS_WHITE : (pix == PIX_BLACK) ? CLS_BLACK : CLS_NONE;
    row_cls[col] = cls;
    if (trk_row == 0 && cls == CLS_WHITE) trk_whites = trk_whites + 11'd1;
    // A pixel at or past the last column closes the row, also after a width shrink.
    if (col + 1 < w) begin
      trk_col_cnt = col + 1;
      return;
    end
    trk_col_cnt = 0;

    if (trk_row == 0) begin
      // First row: seed on the middle white pixel, or column 0 with fewer than two.
      seed = 0;
      if (trk_whites >= 2) begin
        n = 0;
        for (int i = 0; i < w; i++) begin
          if (row_cls[i] == CLS_WHITE) n++;
          if (n == int'(trk_whites) / 2) begin
            seed = i;
            break;
          end
        end
      end
      find_edges(seed, w, lft, rgt);
      trk = seed;
      wid = rgt - lft;
    end else begin
      // Later rows: seed on the previous column, clamped; a non-white seed loses the track.
      seed = (trk_prev > w - 1) ? w - 1 : trk_prev;
      if (row_cls[seed] != CLS_WHITE) begin
        lost = 1'b1;
      end else begin
        find_edges(seed, w, lft, rgt);
        trk = (lft + rgt) / 2;
        wid = rgt - lft;
        dlt = trk - trk_prev;
      end
    end
    if (!lost) cen = trk - int'(reg_center);
    done = lost || (trk_row + 1 >= h);

    res.row  = trk_row[8:0];
    res.col  = trk[9:0];
    res.cen  = cen[10:0];
    res.wid  = wid[11:0];
    res.dlt  = dlt[10:0];
    res.lost = lost;
    res.done = done;
    expected_rows.push_back(res);
    rows_predicted++;

    if (!lost) trk_prev = trk & 1023;
    if (done) trk_stopped = 1'b1;
    else trk_row = (trk_row + 1) & 511;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Result side: compare every accepted word with the oldest pending row, and pick a stall.
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      out_hold = rx_calm ? 0 : $urandom_range(0, 14);
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("result for row %0d with no row pending", out_tdata[8:0]));
      end else begin
        want = expected_rows.pop_front();
        check_field("row_index",       out_tdata[8:0],   want.row);
        check_field("track_column",    out_tdata[18:9],  want.col);
        check_field("centered_column", out_tdata[29:19], want.cen);
        check_field("track_width",     out_tdata[41:30], want.wid);
        check_field("column_delta",    out_tdata[52:42], want.dlt);
        check_field("tdata pad",       out_tdata[55:53], 3'd0);
        check_field("track_lost",      out_tuser,        want.lost);
        check_field("frame_done",      out_tlast,        want.done);
      end
    end
  end

  // Hold tready low for the drawn number of cycles after each result word.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Drive one pixel word after a random gap and wait for the handshake.
  // Enter and leave at a falling edge; tvalid stays high for a back-to-back word.
  task automatic send_pixel(input logic [7:0] pix, input logic fs);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    track_pixel(pix, fs);
    @(negedge clk);
  endtask

  // Four pixels of a directed row, lowest byte first.
  task automatic send_quad(input bit fs_first, input logic [31:0] px);
    for (int i = 0; i < 4; i++) send_pixel(px[8*i +: 8], fs_first && i == 0);
  endtask

  // Stop sending until every pending row result has come back.
  task automatic hold_for_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_rows.size() != 0);
  endtask

  // Drain results, then let a full row search finish before touching the registers.
  task automatic wait_idle();
    hold_for_results();
    repeat (2 * eff_width() + 24) @(negedge clk);
  endtask

  task automatic set_config(input int w, input int h, input int c);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FRAME_WIDTH;
    cfg_wdata <= 11'(w);
    @(negedge clk);
    cfg_addr  <= REG_FRAME_HEIGHT;
    cfg_wdata <= 11'(h);
    @(negedge clk);
    cfg_addr  <= REG_CENTER_COLUMN;
    cfg_wdata <= 11'(c);
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_width  = 11'(w);
    reg_height = 10'(h);
    reg_center = 10'(c);
  endtask

  // Build and send one full row around the current track column, or a random one at a frame start.
  task automatic send_row(input bit fs_first, input bit all_white);
    int         w, anchor, lo, hi, r;
    row_shape_t shape;
    logic [7:0] pix;
    w      = eff_width();
    anchor = fs_first ? $urandom_range(0, w - 1) : ((trk_prev > w - 1) ? w - 1 : trk_prev);
    lo     = anchor - $urandom_range(0, w / 2 + 1);
    hi     = anchor + $urandom_range(0, w / 2 + 1);
    r      = $urandom_range(0, 19);
    if (all_white) shape = ROW_WHITE;
    else if (r == 0) shape = ROW_NOISE;
    else if (r == 1) shape = ROW_HOLE;
    else shape = ROW_TRACK;
    for (int c = 0; c < w; c++) begin
      r = $urandom_range(0, 9);
      case (shape)
        ROW_WHITE: begin
          pix = PIX_WHITE;
        end
        ROW_NOISE: begin
          pix = (r < 3) ? PIX_BLACK : (r < 6) ? PIX_WHITE : 8'($urandom_range(0, 255));
        end
        default: begin
          if (c >= lo && c <= hi)
            pix = (shape == ROW_HOLE && c == anchor) ? 8'($urandom_range(0, 254)) : PIX_WHITE;
          else
            pix = (r < 6) ? PIX_BLACK : (r < 8) ? PIX_WHITE : 8'($urandom_range(1, 254));
        end
      endcase
      send_pixel(pix, fs_first && c == 0);
      pixels_sent++;
    end
  endtask

  // Send rows until the frame is done or the track is lost; now and then restart the frame.
  task automatic run_frame(input bit all_white);
    send_row(1'b1, all_white);
    while (!trk_stopped) begin
      if (!all_white && $urandom_range(0, 9) == 0) hold_for_results();
      send_row(!all_white && $urandom_range(0, 24) == 0, all_white);
    end
  endtask

  // One setting of the registers and a few frames under it.
  task automatic run_phase(input int w, input int h, input int c, input int frames,
                           input bit all_white);
    wait_idle();
    set_config(w, h, c);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    repeat (frames) begin
      run_frame(all_white);
      // Pixels while stopped must be dropped without a result.
      if (!all_white && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_pixel(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Short rows by hand: dropped pixels after reset, first-row seeding with and without
  // enough white, no black on one side, a lost track, the last row, a restart mid-frame.
  task automatic test_directed_frames();
    set_config(4, 2, 1);
    send_pixel(PIX_WHITE, 1'b0);
    send_quad(1'b1, {8'd128, 8'd255, 8'd255, 8'd0});
    send_quad(1'b0, {8'd255, 8'd0, 8'd255, 8'd255});
    send_quad(1'b1, {8'd0, 8'd255, 8'd254, 8'd1});
    send_quad(1'b0, {8'd255, 8'd255, 8'd255, 8'd0});
    send_pixel(PIX_WHITE, 1'b1);
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(8'd7, 1'b0);
    send_quad(1'b1, {4{8'd255}});
    send_pixel(PIX_WHITE, 1'b0);
    send_pixel(PIX_WHITE, 1'b0);
  endtask

  // Shrink the width while a row is half in: the next pixel closes the row.
  task automatic test_width_shrink();
    wait_idle();
    set_config(2, 2, 0);
    send_pixel(PIX_WHITE, 1'b0);
  endtask

  // Mostly tracked frames with random content over many small register settings,
  // out-of-range width and height among them.
  task automatic test_random_traffic();
    int px0, rows0, w, h, c, pick;
    px0   = pixels_sent;
    rows0 = rows_predicted;
    while (pixels_sent - px0 < 500 || rows_predicted - rows0 < 48) begin
      w    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      h    = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
      pick = $urandom_range(0, 3);
      c    = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 1023);
      run_phase(w, h, c, $urandom_range(1, 4), 1'b0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_frames();
    test_width_shrink();
    test_random_traffic();

    // Drain the last results and give the block time to raise anything stray.
    hold_for_results();
    repeat (2 * eff_width() + 24) @(negedge clk);
    if (mismatches == 0) begin
      $display("** track_center_line_follower_core: PASSED **");
    end else begin
      $display("** track_center_line_follower_core: FAILED **");
    end
    $finish;
  end

endmodule
